>>> rtl/tsts_pkg.sv
// ----------------------------------------------------------------------------
// tsts_pkg
// Shared types, codes and constants of the time-slice task scheduler.
// ----------------------------------------------------------------------------
package tsts_pkg;

   // Default number of task slots and the slot index width the records carry.
   localparam int NUM_SLOTS_DEF = 16;
   localparam int IDX_W         = 6;

   // Operation codes of a request transaction.
   localparam logic [2:0] FN_TICK  = 3'd0;
   localparam logic [2:0] FN_SLEEP = 3'd1;
   localparam logic [2:0] FN_YIELD = 3'd2;
   localparam logic [2:0] FN_WRITE = 3'd3;
   localparam logic [2:0] FN_MASK  = 3'd4;

   // Task status codes.
   localparam logic [2:0] ST_RUN      = 3'd0;
   localparam logic [2:0] ST_SLEEP    = 3'd1;
   localparam logic [2:0] ST_STOP     = 3'd2;
   localparam logic [2:0] ST_BLOCK    = 3'd3;
   localparam logic [2:0] ST_EXIT     = 3'd4;
   localparam logic [2:0] ST_DISPOSED = 3'd5;

   // Command broadcast from the sequencer to every slot cell.
   typedef struct packed {
      logic             wr;
      logic             dec;
      logic             sleep;
      logic             clean;
      logic             refill;
      logic [IDX_W-1:0] cur;
      logic [IDX_W-1:0] wslot;
      logic             present;
      logic [2:0]       status;
      logic [7:0]       prio;
      logic [8:0]       counter;
      logic [31:0]      wake;
      logic [31:0]      now;
   } cmd_type;

   // Best candidate handed from one cell to the next.
   typedef struct packed {
      logic             found;
      logic [8:0]       counter;
      logic [IDX_W-1:0] idx;
   } best_type;

endpackage

>>> rtl/tsts_req_if.sv
// ----------------------------------------------------------------------------
// tsts_req_if
// Request channel: valid, ready and one request transaction.
// ----------------------------------------------------------------------------
interface tsts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] now_ms;
   logic [15:0] duration_ms;
   logic [3:0]  slot;
   logic        present;
   logic [2:0]  status;
   logic [7:0]  priority_req;
   logic [8:0]  counter_value;
   logic        mask;

   modport source (output valid, func, now_ms, duration_ms, slot, present, status,
                   priority_req, counter_value, mask, input ready);
   modport sink   (input valid, func, now_ms, duration_ms, slot, present, status,
                   priority_req, counter_value, mask, output ready);
endinterface

>>> rtl/tsts_rsp_if.sv
// ----------------------------------------------------------------------------
// tsts_rsp_if
// Response channel: valid, ready and one response transaction.
// ----------------------------------------------------------------------------
interface tsts_rsp_if;
   logic       valid;
   logic       ready;
   logic       scheduled;
   logic [3:0] current_slot;
   logic [8:0] current_counter;

   modport source (output valid, scheduled, current_slot, current_counter,
                   input ready);
   modport sink   (input valid, scheduled, current_slot, current_counter,
                   output ready);
endinterface

>>> rtl/tsts_cell.sv
// ----------------------------------------------------------------------------
// tsts_cell
// One task slot: its state, the broadcast commands acting on it, and one
// registered stage of the maximum-counter selection chain.
// ----------------------------------------------------------------------------
module tsts_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  tsts_pkg::cmd_type   cmd,
   input  tsts_pkg::best_type  best_i,
   output tsts_pkg::best_type  best_o,
   output logic                present_o,
   output logic [8:0]          counter_o
);

   logic               present_ff, present_in;
   logic [2:0]         status_ff, status_in;
   logic [8:0]         counter_ff, counter_in;
   logic [7:0]         prio_ff, prio_in;
   logic [31:0]        wake_ff, wake_in;
   tsts_pkg::best_type best_ff, best_in;

   logic is_cur, is_wr, dying, cand;

   assign is_cur = (cmd.cur == tsts_pkg::IDX_W'(IDX));
   assign is_wr  = cmd.wr && (cmd.wslot == tsts_pkg::IDX_W'(IDX));
   assign dying  = (status_ff == tsts_pkg::ST_EXIT) || (status_ff == tsts_pkg::ST_DISPOSED);

   // Slot state update from the broadcast command.
   always_comb begin
      present_in = present_ff;
      status_in  = status_ff;
      counter_in = counter_ff;
      prio_in    = prio_ff;
      wake_in    = wake_ff;
      if (is_wr) begin
         present_in = cmd.present;
         status_in  = cmd.status;
         prio_in    = cmd.prio;
         counter_in = cmd.counter;
      end
      if (cmd.dec && is_cur && counter_ff != 9'd0) begin
         counter_in = counter_ff - 9'd1;
      end
      if (cmd.sleep && is_cur) begin
         wake_in   = cmd.wake;
         status_in = tsts_pkg::ST_SLEEP;
      end
      if (cmd.clean && present_ff) begin
         if (dying) begin
            if (!is_cur) begin
               present_in = 1'b0;
            end
         end else if (status_ff != tsts_pkg::ST_STOP && status_ff != tsts_pkg::ST_BLOCK &&
                      cmd.now > wake_ff) begin
            status_in = tsts_pkg::ST_RUN;
         end
      end
      if (cmd.refill && present_ff) begin
         counter_in = {1'b0, prio_ff} + {1'b0, counter_ff[8:1]};
      end
   end

   // Selection stage: a strictly larger counter replaces the incoming best, so
   // the lower index keeps ties.
   assign cand = present_ff && (status_ff == tsts_pkg::ST_RUN);

   always_comb begin
      best_in = best_i;
      if (cand && (!best_i.found || counter_ff > best_i.counter)) begin
         best_in.found   = 1'b1;
         best_in.counter = counter_ff;
         best_in.idx     = tsts_pkg::IDX_W'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         status_ff  <= tsts_pkg::ST_RUN;
         counter_ff <= 9'd0;
         prio_ff    <= 8'd1;
         wake_ff    <= 32'd0;
         best_ff    <= '0;
      end else begin
         present_ff <= present_in;
         status_ff  <= status_in;
         counter_ff <= counter_in;
         prio_ff    <= prio_in;
         wake_ff    <= wake_in;
         best_ff    <= best_in;
      end
   end

   assign best_o    = best_ff;
   assign present_o = present_ff;
   assign counter_o = counter_ff;

endmodule

>>> rtl/time_slice_task_scheduler.sv
// ----------------------------------------------------------------------------
// time_slice_task_scheduler
// Sequencer over a chain of slot cells; one request in, one response out.
// ----------------------------------------------------------------------------
// Sequence: write, mask and non-scheduling ticks go from the accepting state
// straight to the response state. A schedule pass runs clean, one scan and
// evaluation, plus a second scan and evaluation when the counters are refilled;
// each scan ripples the best candidate through the cell chain one cell per cycle. One request is in work at a time.
// Reset is synchronous: the slot table is cleared, priorities set to one.
// ----------------------------------------------------------------------------
module time_slice_task_scheduler #(
   parameter int NUM_SLOTS = tsts_pkg::NUM_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tsts_req_if.sink   req_ch,
   tsts_rsp_if.source rsp_ch
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int XW = (IW > 4) ? IW : 4;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAN = 5'b00010,
      S_SCAN  = 5'b00100,
      S_EVAL  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [IW-1:0]      running_ff, running_in;
   logic [IW-1:0]      scan_ff, scan_in;
   logic               pass2_ff, pass2_in;
   logic               sched_ff, sched_in;
   logic               masked_ff, masked_in;
   logic [31:0]        now_ff, now_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_sched_ff, rsp_sched_in;
   logic [3:0]         rsp_slot_ff, rsp_slot_in;
   logic [8:0]         rsp_cnt_ff, rsp_cnt_in;

   tsts_pkg::cmd_type  cmd;
   tsts_pkg::best_type best_w [NUM_SLOTS+1];
   logic [8:0]         counter_w [NUM_SLOTS];
   logic               present_w [NUM_SLOTS];
   logic [8:0]         cur_cnt;
   logic [32:0]        wake_sum;
   logic [XW-1:0]      run_ext;
   logic               accept;

   // Cell chain.
   assign best_w[0] = '0;
   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      tsts_cell #(.IDX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .best_i    (best_w[g]),
         .best_o    (best_w[g+1]),
         .present_o (present_w[g]),
         .counter_o (counter_w[g])
      );
   end

   assign cur_cnt  = counter_w[running_ff];
   assign wake_sum = {1'b0, req_ch.now_ms} + {17'b0, req_ch.duration_ms};
   assign accept   = req_ch.valid && req_ch.ready;
   assign run_ext  = XW'(running_ff);
   assign req_ch.ready = (state_ff == S_IDLE);

   // Sequencer and command broadcast.
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      scan_in      = scan_ff;
      pass2_in     = pass2_ff;
      sched_in     = sched_ff;
      masked_in    = masked_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_sched_in = rsp_sched_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      cmd         = '0;
      cmd.cur     = tsts_pkg::IDX_W'(running_ff);
      cmd.wslot   = tsts_pkg::IDX_W'(req_ch.slot);
      cmd.present = req_ch.present;
      cmd.status  = req_ch.status;
      cmd.prio    = req_ch.priority_req;
      cmd.counter = req_ch.counter_value;
      cmd.wake    = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];
      cmd.now     = now_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in   = req_ch.now_ms;
               sched_in = 1'b0;
               pass2_in = 1'b0;
               state_in = S_DONE;
               case (req_ch.func)
                  tsts_pkg::FN_TICK: begin
                     if (!masked_ff) begin
                        cmd.dec = 1'b1;
                        if (cur_cnt <= 9'd1) begin
                           state_in = S_CLEAN;
                        end
                     end
                  end
                  tsts_pkg::FN_SLEEP: begin
                     cmd.sleep = 1'b1;
                     state_in  = S_CLEAN;
                  end
                  tsts_pkg::FN_YIELD: state_in = S_CLEAN;
                  tsts_pkg::FN_WRITE: begin
                     cmd.wr = ({28'b0, req_ch.slot} < 32'(NUM_SLOTS));
                  end
                  tsts_pkg::FN_MASK: masked_in = req_ch.mask;
                  default: ;
               endcase
            end
         end
         S_CLEAN: begin
            cmd.clean = 1'b1;
            scan_in   = '0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            scan_in = scan_ff + IW'(1);
            if (scan_ff == IW'(NUM_SLOTS - 1)) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (best_w[NUM_SLOTS].found && best_w[NUM_SLOTS].counter == 9'd0 && !pass2_ff) begin
               // Every running counter is spent: refill and scan once more.
               cmd.refill = 1'b1;
               pass2_in   = 1'b1;
               scan_in    = '0;
               state_in   = S_SCAN;
            end else begin
               if (best_w[NUM_SLOTS].found) begin
                  running_in = best_w[NUM_SLOTS].idx[IW-1:0];
                  sched_in   = 1'b1;
               end else if (present_w[0]) begin
                  running_in = '0;
                  sched_in   = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sched_in = sched_ff;
               rsp_slot_in  = run_ext[3:0];
               rsp_cnt_in   = cur_cnt;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         scan_ff      <= '0;
         pass2_ff     <= 1'b0;
         sched_ff     <= 1'b0;
         masked_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         scan_ff      <= scan_in;
         pass2_ff     <= pass2_in;
         sched_ff     <= sched_in;
         masked_ff    <= masked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      rsp_sched_ff <= rsp_sched_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.scheduled       = rsp_sched_ff;
   assign rsp_ch.current_slot    = rsp_slot_ff;
   assign rsp_ch.current_counter = rsp_cnt_ff;

endmodule
